[rtl/sph_pkg.sv]
// Shared constants, datapath command codes and command struct for the service port hash.
package sph_pkg;

    // FNV-1a 64-bit hash constants; the prime is 2^40 + 0x1b3
    localparam logic [63:0] FNV_BASIS       = 64'hCBF2_9CE4_8422_2325;
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;

    // splitmix64 mixer constants
    localparam logic [63:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL2  = 64'h94D0_49BB_1331_11EB;

    // Round count saturation
    localparam logic [15:0] MAX_RETRIES = 16'd255;

    // Port mapping: ((h & 0xFFF) * 677) / 100 + 5001
    localparam int          PORT_W      = 15;
    localparam logic [21:0] PORT_MUL    = 22'd677;
    localparam logic [PORT_W-1:0] PORT_BASE = 15'd5001;
    // Divide by 100 as multiply by ceil(2^29 / 100), exact for products below 2^22
    localparam int          RECIP_SHIFT = 29;
    localparam logic [22:0] RECIP_MUL   = 23'd5368710;

    // Datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_FOLD,
        DP_GAMMA,
        DP_MUL_LL,
        DP_MUL_LH,
        DP_MUL_HL,
        DP_XOR27,
        DP_XOR31,
        DP_SCALE,
        DP_RECIP,
        DP_EMIT
    } t_dp_op;

    // Command from controller to datapath
    typedef struct packed {
        t_dp_op op;
        logic   mul_sel;   // 0: first mixer multiplier, 1: second
    } t_dp_cmd;

endpackage

[rtl/service_port_hash.sv]
// Service port hash: FNV-1a over name bytes, splitmix64 rounds, mapped to a port number.
// Name-byte requests without last are taken one per cycle, folded in the accept cycle.
// A last request runs its mixer rounds (rounds = retry count), then port scaling and emit;
// the mixer's 64-bit multiplies are each done as three 32x32 partial products.
// Input is ready in the cycle the result appears; an untaken result stalls the emit step.
// Synchronous active-low reset loads the FNV offset basis and clears any pending result.
module service_port_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_name_byte,
    input  logic                       i_byte_valid,
    input  logic                       i_last,
    input  logic [7:0]                 i_retry_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sph_pkg::PORT_W-1:0] o_port
);

    sph_pkg::t_dp_cmd w_cmd;

    // Sequence requests and mixer rounds
    sph_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_byte_valid  (i_byte_valid),
        .i_last        (i_last),
        .i_retry_count (i_retry_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cmd         (w_cmd)
    );

    // Hash, mix and scale
    sph_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_name_byte (i_name_byte),
        .o_port      (o_port)
    );

endmodule

[rtl/sph_datapath.sv]
// Datapath: running FNV-1a hash, split splitmix64 multiplier, port scaling and output register.
module sph_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sph_pkg::t_dp_cmd           i_cmd,
    input  logic [7:0]                 i_name_byte,
    output logic [sph_pkg::PORT_W-1:0] o_port
);

    logic [63:0] r_hash;
    logic [63:0] r_z;
    logic [63:0] r_p;
    logic [sph_pkg::PORT_W-1:0] r_port;

    logic [63:0] w_fold_x;
    logic [63:0] w_fold;
    logic [63:0] w_gamma;
    logic [63:0] w_mul_c;
    logic [63:0] w_ll;
    logic [31:0] w_lh;
    logic [31:0] w_hl;
    logic [21:0] w_scaled;
    logic [44:0] w_recip;

    // FNV-1a fold: xor in the byte, multiply by 2^40 + 0x1b3
    assign w_fold_x = r_hash ^ {56'd0, i_name_byte};
    assign w_fold   = (w_fold_x << sph_pkg::FNV_PRIME_SHIFT)
                    + (w_fold_x * {55'd0, sph_pkg::FNV_PRIME_LO});

    // Mixer add and partial products of the 64x64 multiply, modulo 2^64
    assign w_gamma = r_hash + sph_pkg::MIX_GAMMA;
    assign w_mul_c = i_cmd.mul_sel ? sph_pkg::MIX_MUL2 : sph_pkg::MIX_MUL1;
    assign w_ll    = {32'd0, r_z[31:0]} * {32'd0, w_mul_c[31:0]};
    assign w_lh    = r_z[31:0] * w_mul_c[63:32];
    assign w_hl    = r_z[63:32] * w_mul_c[31:0];

    // Port scaling
    assign w_scaled = {10'd0, r_hash[11:0]} * sph_pkg::PORT_MUL;
    assign w_recip  = {23'd0, r_p[21:0]} * {22'd0, sph_pkg::RECIP_MUL};

    // Hold the running hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= sph_pkg::FNV_BASIS;
        end else begin
            case (i_cmd.op)
                sph_pkg::DP_FOLD:  r_hash <= w_fold;
                sph_pkg::DP_XOR31: r_hash <= r_p ^ (r_p >> 31);
                sph_pkg::DP_EMIT:  r_hash <= sph_pkg::FNV_BASIS;
                default:           r_hash <= r_hash;
            endcase
        end
    end

    // Advance the mixer and scaling registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            sph_pkg::DP_GAMMA:  r_z <= w_gamma ^ (w_gamma >> 30);
            sph_pkg::DP_XOR27:  r_z <= r_p ^ (r_p >> 27);
            default:            r_z <= r_z;
        endcase
        case (i_cmd.op)
            sph_pkg::DP_MUL_LL: r_p <= w_ll;
            sph_pkg::DP_MUL_LH: r_p <= r_p + {w_lh, 32'd0};
            sph_pkg::DP_MUL_HL: r_p <= r_p + {w_hl, 32'd0};
            sph_pkg::DP_SCALE:  r_p <= {42'd0, w_scaled};
            sph_pkg::DP_RECIP:  r_p <= {19'd0, w_recip};
            default:            r_p <= r_p;
        endcase
        if (i_cmd.op == sph_pkg::DP_EMIT) begin
            r_port <= r_p[sph_pkg::RECIP_SHIFT +: sph_pkg::PORT_W] + sph_pkg::PORT_BASE;
        end
    end

    assign o_port = r_port;

endmodule

[rtl/sph_ctrl.sv]
// Controller: request handshakes, mixer round sequencing and result valid.
module sph_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_byte_valid,
    input  logic             i_last,
    input  logic [7:0]       i_retry_count,
    output logic             o_valid,
    input  logic             i_ready,
    output sph_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAMMA,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_XOR27,
        S_XOR31,
        S_SCALE,
        S_RECIP,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic       r_out_valid;
    logic [7:0] r_rounds;
    logic       r_second;

    logic       w_accept;
    logic       w_can_emit;
    logic [7:0] w_rounds;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign w_accept   = i_valid && o_ready;
    assign w_can_emit = !r_out_valid || i_ready;

    // Saturate the round count
    assign w_rounds = ({8'd0, i_retry_count} > sph_pkg::MAX_RETRIES)
                    ? sph_pkg::MAX_RETRIES[7:0] : i_retry_count;

    // Drive the datapath command
    always_comb begin
        o_cmd.op      = sph_pkg::DP_NOP;
        o_cmd.mul_sel = r_second;
        case (r_state)
            S_IDLE:  if (w_accept && i_byte_valid) o_cmd.op = sph_pkg::DP_FOLD;
            S_GAMMA: o_cmd.op = sph_pkg::DP_GAMMA;
            S_MUL0:  o_cmd.op = sph_pkg::DP_MUL_LL;
            S_MUL1:  o_cmd.op = sph_pkg::DP_MUL_LH;
            S_MUL2:  o_cmd.op = sph_pkg::DP_MUL_HL;
            S_XOR27: o_cmd.op = sph_pkg::DP_XOR27;
            S_XOR31: o_cmd.op = sph_pkg::DP_XOR31;
            S_SCALE: o_cmd.op = sph_pkg::DP_SCALE;
            S_RECIP: o_cmd.op = sph_pkg::DP_RECIP;
            S_EMIT:  if (w_can_emit) o_cmd.op = sph_pkg::DP_EMIT;
            default: o_cmd.op = sph_pkg::DP_NOP;
        endcase
    end

    // Hold state, round count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rounds    <= 8'd0;
            r_second    <= 1'b0;
        end else begin
            // Drop a taken result; the emit step reloads it itself
            if (r_out_valid && i_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_last) begin
                        r_rounds <= w_rounds;
                        r_state  <= (w_rounds == 8'd0) ? S_SCALE : S_GAMMA;
                    end
                end
                S_GAMMA: begin
                    r_second <= 1'b0;
                    r_state  <= S_MUL0;
                end
                S_MUL0:  r_state <= S_MUL1;
                S_MUL1:  r_state <= S_MUL2;
                S_MUL2:  r_state <= r_second ? S_XOR31 : S_XOR27;
                S_XOR27: begin
                    r_second <= 1'b1;
                    r_state  <= S_MUL0;
                end
                S_XOR31: begin
                    r_rounds <= r_rounds - 8'd1;
                    r_state  <= (r_rounds == 8'd1) ? S_SCALE : S_GAMMA;
                end
                S_SCALE: r_state <= S_RECIP;
                S_RECIP: r_state <= S_EMIT;
                S_EMIT: begin
                    if (w_can_emit) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A released result shows up valid and the block returns to idle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_can_emit) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after emit");

    // A last request with no rounds goes straight to scaling
    a_zero_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last && w_rounds == 8'd0) |=> (r_state == S_SCALE))
        else $error("zero-round request entered the mixer");

    // The final round ends in scaling
    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XOR31 && r_rounds == 8'd1) |=> (r_state == S_SCALE))
        else $error("mixer ran past its round count");

    // The first multiply of a round is followed by its xor-shift
    a_first_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL2 && !r_second) |=> (r_state == S_XOR27 && r_second == 1'b0))
        else $error("mixer step order broken");

endmodule

[tb/service_port_hash_tb.sv]
// Testbench for service_port_hash: random service names checked against a hash and port predictor.
`timescale 1ns / 100ps

module service_port_hash_tb;

    // Hash and port-mapping constants for the predictor
    localparam logic [63:0] NAME_HASH_SEED = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] NAME_HASH_MUL  = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] STIR_STEP      = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] STIR_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] STIR_MUL_B     = 64'h94D0_49BB_1331_11EB;
    localparam int          ROUND_CAP      = 255;
    localparam int          SPAN_MUL       = 677;
    localparam int          SPAN_DIV       = 100;
    localparam int          FIRST_PORT     = 5001;
    localparam int          PW             = sph_pkg::PORT_W;

    localparam int NAME_ITEMS    = 1200;
    localparam int HOLD_CYCLES   = 1500;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int REPORT_LIMIT  = 10;

    // Track the running name hash and the ports it owes
    class port_hash_tracker;
        logic [63:0]   name_hash;
        logic [PW-1:0] pending_ports[$];
        int            mismatches;
        int            ports_seen;

        function new();
            name_hash  = NAME_HASH_SEED;
            mismatches = 0;
            ports_seen = 0;
        endfunction

        // Fold an accepted request; on a last request, stir and map to a port
        function void fold_request(logic [7:0] name_byte, logic byte_valid, logic last,
                                   logic [7:0] retry);
            int          rounds;
            logic [63:0] z;
            logic [31:0] scaled;
            if (byte_valid)
                name_hash = (name_hash ^ {56'd0, name_byte}) * NAME_HASH_MUL;
            if (last) begin
                rounds = (int'(retry) > ROUND_CAP) ? ROUND_CAP : int'(retry);
                for (int r = 0; r < rounds; r++) begin
                    name_hash = name_hash + STIR_STEP;
                    z = name_hash;
                    z = (z ^ (z >> 30)) * STIR_MUL_A;
                    z = (z ^ (z >> 27)) * STIR_MUL_B;
                    z = z ^ (z >> 31);
                    name_hash = z;
                end
                scaled = ({20'd0, name_hash[11:0]} * SPAN_MUL) / SPAN_DIV + FIRST_PORT;
                pending_ports.push_back(scaled[PW-1:0]);
                name_hash = NAME_HASH_SEED;
            end
        endfunction

        // Compare a delivered port with the oldest one owed
        function void match_port(logic [PW-1:0] got);
            logic [PW-1:0] want;
            ports_seen++;
            if (pending_ports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("port %0d delivered with no name pending", got);
            end else begin
                want = pending_ports.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("port wrong: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_valid       = 1'b0;
    logic          o_ready;
    logic [7:0]    i_name_byte   = 8'd0;
    logic          i_byte_valid  = 1'b0;
    logic          i_last        = 1'b0;
    logic [7:0]    i_retry_count = 8'd0;
    logic          o_valid;
    logic          i_ready       = 1'b0;
    logic [PW-1:0] o_port;

    port_hash_tracker ledger = new();
    int               name_items_sent = 0;
    int               burst_left      = 0;

    service_port_hash DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_name_byte   (i_name_byte),
        .i_byte_valid  (i_byte_valid),
        .i_last        (i_last),
        .i_retry_count (i_retry_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_port        (o_port)
    );

    always #10 i_clk = ~i_clk;

    // Check each port taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            ledger.match_port(o_port);
    end

    // Offer one request and hold it until taken; idle between bursts
    task automatic send_request(input logic [7:0] name_byte, input logic byte_valid,
                                input logic last, input logic [7:0] retry);
        int gap;
        i_valid       <= 1'b1;
        i_name_byte   <= name_byte;
        i_byte_valid  <= byte_valid;
        i_last        <= last;
        i_retry_count <= retry;
        do @(posedge i_clk); while (!o_ready);
        ledger.fold_request(name_byte, byte_valid, last, retry);
        if (byte_valid || last)
            name_items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap           = $urandom_range(1, 12);
            i_valid       <= 1'b0;
            i_name_byte   <= 8'($urandom_range(0, 255));
            i_byte_valid  <= 1'($urandom_range(0, 1));
            i_last        <= 1'($urandom_range(0, 1));
            i_retry_count <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // Mostly small round counts, now and then near the top of the range
    function automatic logic [7:0] pick_rounds();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'($urandom_range(0, 3));
        else if (r < 85)
            return 8'($urandom_range(4, 20));
        else if (r < 97)
            return 8'($urandom_range(21, 100));
        return 8'($urandom_range(200, 255));
    endfunction

    // Mostly lowercase letters, otherwise any byte
    function automatic logic [7:0] pick_name_char();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one name with random content, stray ignored bytes, and either end style
    task automatic send_random_name();
        int         len;
        logic       fused;
        logic [7:0] b;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
        fused = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0,
                             8'($urandom_range(0, 255)));
            b = pick_name_char();
            if (fused && k == len - 1)
                send_request(b, 1'b1, 1'b1, pick_rounds());
            else
                send_request(b, 1'b1, 1'b0, 8'($urandom_range(0, 255)));
        end
        if (!fused)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, pick_rounds());
    endtask

    // Stimulus: reset, directed names, random names, then drain
    initial begin
        int waited;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty name with no rounds and with full rounds
        send_request(8'h00, 1'b0, 1'b1, 8'd0);
        send_request(8'h5A, 1'b0, 1'b1, 8'd255);
        // a lone zero byte is part of the name
        send_request(8'h00, 1'b1, 1'b1, 8'd1);
        // zero byte mid-name, with an ignored byte in between
        send_request(8'hFF, 1'b1, 1'b0, 8'h00);
        send_request(8'hAA, 1'b0, 1'b0, 8'hFF);
        send_request(8'h00, 1'b1, 1'b0, 8'h12);
        send_request(8'h80, 1'b1, 1'b1, 8'd2);
        // name closed by a request with no valid byte
        send_request(8'h01, 1'b1, 1'b0, 8'd0);
        send_request(8'h7F, 1'b1, 1'b0, 8'd0);
        send_request(8'h33, 1'b0, 1'b1, 8'd255);
        // a short text name
        send_request(8'h73, 1'b1, 1'b0, 8'd0);
        send_request(8'h76, 1'b1, 1'b0, 8'd0);
        send_request(8'h63, 1'b1, 1'b1, 8'd3);
        // single byte extremes and an empty name again
        send_request(8'hFF, 1'b1, 1'b1, 8'd0);
        send_request(8'h00, 1'b0, 1'b1, 8'd128);
        send_request(8'h55, 1'b1, 1'b1, 8'd255);

        while (name_items_sent < NAME_ITEMS)
            send_random_name();
        i_valid <= 1'b0;

        // Wait for every owed port, then keep watching for strays
        waited = 0;
        while (ledger.pending_ports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);

        if (ledger.pending_ports.size() != 0)
            $display("%0d ports never delivered", ledger.pending_ports.size());
        if (ledger.mismatches == 0 && ledger.pending_ports.size() == 0)
            $display("service_port_hash: match");
        else
            $display("service_port_hash: mismatch");
        $finish;
    end

    // Receiver: alternate ready patterns, with one long hold-off early on
    initial begin
        int mode;
        int stretch;
        int beat;
        bit held_off;
        held_off = 1'b0;
        beat     = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(20, 200);
            repeat (stretch) begin
                if (!held_off && ledger.ports_seen >= 15) begin
                    held_off = 1'b1;
                    i_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: begin
                        i_ready <= 1'b1;
                    end
                    1: begin
                        i_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_ready <= (beat % 8) < 2;
                    end
                endcase
                beat++;
                @(posedge i_clk);
            end
        end
    end

    // Hard stop for a hung run
    initial begin
        #300_000_000;
        $display("service_port_hash: mismatch");
        $finish;
    end

endmodule
